>>> src/llrm_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and keyword table for the line receiver/matcher.
// No dependencies.
package llrm_pkg;

    localparam int KW_COUNT   = 23;
    localparam int KW_W       = 24;   // alive vector, top bit spare
    localparam int KW_MAX_LEN = 22;
    localparam int ROW_W      = $clog2(KW_MAX_LEN + 1);
    localparam int KW_TXT_W   = KW_MAX_LEN * 8;

    // Keyword indices with a special role
    localparam int KW_FAULT      = 0;
    localparam int KW_STATE      = 1;
    localparam int KW_HOST       = 2;
    localparam int KW_PONG       = 3;
    localparam int KW_ACK_REL    = 4;
    localparam int KW_ACK_TAKE   = 5;
    localparam int KW_ST_FIRST   = 6;
    localparam int KW_HOST_FIRST = 14;

    // Text fragments shared by several keywords
    localparam logic [23:0]  TAG_HOST = 24'h4E5246;
    localparam logic [23:0]  TAG_PEER = 24'h455350;
    localparam logic [71:0]  TXT_ACK  = "ACK_AUDIO";
    localparam logic [31:0]  TXT_CONV = "CONV";

    // Right-aligned text, first character is the most significant byte in use
    localparam logic [KW_TXT_W-1:0] KW_TEXT [KW_COUNT] = '{
        KW_TXT_W'("FAULT:"),
        KW_TXT_W'("STATE:"),
        KW_TXT_W'({TAG_HOST, ":"}),
        KW_TXT_W'({TAG_PEER, "_PONG"}),
        KW_TXT_W'({TXT_ACK, "_RELEASE"}),
        KW_TXT_W'({TXT_ACK, "_TAKE"}),
        KW_TXT_W'("STATE:SAFE"),
        KW_TXT_W'("STATE:SAFE_HANDOFF"),
        KW_TXT_W'({"STATE:", TAG_HOST, "_OWNER"}),
        KW_TXT_W'({"STATE:", TAG_HOST, "_AUDIO_OWNER"}),
        KW_TXT_W'({"STATE:", TAG_PEER, "_OWNER"}),
        KW_TXT_W'({"STATE:", TAG_PEER, "_AUDIO_OWNER"}),
        KW_TXT_W'("STATE:BOOTCTRL"),
        KW_TXT_W'({"STATE:", TAG_HOST, "_", TAG_PEER, "_BOOTCTRL"}),
        KW_TXT_W'({TAG_HOST, ":", TAG_PEER, "_DL"}),
        KW_TXT_W'({TAG_HOST, ":", TAG_PEER, "_BOOT"}),
        KW_TXT_W'({TAG_HOST, ":", TAG_PEER, "_RST"}),
        KW_TXT_W'({TAG_HOST, ":", TAG_PEER, "_FW_BEGIN"}),
        KW_TXT_W'({TAG_HOST, ":", TAG_PEER, "_FW_END"}),
        KW_TXT_W'({TAG_HOST, ":", TAG_PEER, "_PING"}),
        KW_TXT_W'({TAG_HOST, ":", TXT_CONV, "_START"}),
        KW_TXT_W'({TAG_HOST, ":", TXT_CONV, "_STOP"}),
        KW_TXT_W'({TAG_HOST, ":", TXT_CONV, "_END"})
    };

    localparam int KW_LEN [KW_COUNT] = '{
        6, 6, 4, 8, 17, 14, 10, 18, 15, 21, 15, 21, 14, 22,
        10, 12, 11, 16, 14, 12, 14, 13, 12
    };

    // Prefix keywords stay alive past their end
    localparam logic [KW_COUNT-1:0] KW_PREFIX = KW_COUNT'(23'b111);

    localparam logic [2:0] KW_CODE [KW_COUNT] = '{
        3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0,
        3'd1, 3'd1, 3'd2, 3'd2, 3'd3, 3'd3, 3'd4, 3'd4,
        3'd1, 3'd2, 3'd3, 3'd1, 3'd2, 3'd4, 3'd5, 3'd6, 3'd6
    };

    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_FIRST = 8'h20;
    localparam logic [7:0] CH_LAST  = 8'h7E;

    typedef enum logic [1:0] {
        FN_BYTE   = 2'd0,
        FN_FLUSH  = 2'd1,
        FN_ARM    = 2'd2,
        FN_CANCEL = 2'd3
    } func_t;

    localparam logic [2:0] WK_PONG     = 3'd1;
    localparam logic [2:0] WK_STATE    = 3'd2;
    localparam logic [2:0] WK_ACK_REL  = 3'd3;
    localparam logic [2:0] WK_ACK_TAKE = 3'd4;

    localparam logic [2:0] ST_UNKNOWN = 3'd0;
    localparam logic [2:0] ST_FAULT   = 3'd5;

    // One row of the keyword table: character at a given position per keyword
    typedef struct packed {
        logic [KW_COUNT-1:0]      in_range;
        logic [KW_COUNT-1:0][7:0] chars;
    } kw_row_t;

    // Line end event towards the decoder
    typedef struct packed {
        logic                eol;
        logic [KW_COUNT-1:0] hits;
    } line_ev_t;

    function automatic kw_row_t kw_row(input logic [ROW_W-1:0] pos);
        kw_row_t r;
        int      k;
        r = '0;
        for (k = 0; k < KW_COUNT; k++)
        begin
            if (int'(pos) < KW_LEN[k])
            begin
                r.in_range[k] = 1'b1;
                r.chars[k]    = KW_TEXT[k][(KW_LEN[k] - 1 - int'(pos)) * 8 +: 8];
            end
        end
        return r;
    endfunction

endpackage

>>> src/llrm_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for input beats and result beats.
// No dependencies.
interface llrm_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] func;
    logic [7:0] rx_byte;
    logic [2:0] wait_kind;

    modport source (output valid, func, rx_byte, wait_kind, input ready);
    modport sink   (input valid, func, rx_byte, wait_kind, output ready);
endinterface

interface llrm_out_if;
    logic       valid;
    logic       ready;
    logic       is_host_line;
    logic [2:0] host_action;
    logic [2:0] parsed_state;
    logic [2:0] cached_peer_state;
    logic       wait_done;
    logic       wait_fault;
    logic       link_ready;

    modport source (output valid, is_host_line, host_action, parsed_state,
                    cached_peer_state, wait_done, wait_fault, link_ready,
                    input ready);
    modport sink   (input valid, is_host_line, host_action, parsed_state,
                    cached_peer_state, wait_done, wait_fault, link_ready,
                    output ready);
endinterface

>>> src/llrm_kw_rom.sv
`timescale 1ns / 1ps
// Keyword table memory: one row per character position, registered read.
// Depends on llrm_pkg.
module llrm_kw_rom (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [llrm_pkg::ROW_W-1:0] addr,
    output llrm_pkg::kw_row_t     row_reg,
    output logic                  primed_reg
);
    import llrm_pkg::*;

    kw_row_t rom [KW_MAX_LEN + 1];

    always_comb
    begin
        for (int i = 0; i <= KW_MAX_LEN; i++)
        begin
            rom[i] = kw_row(ROW_W'(i));
        end
    end

    always_ff @(posedge clk)
    begin
        row_reg <= rom[addr];
    end

    // Row for the reset position is not present until the register has loaded after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            primed_reg <= 1'b0;
        else
            primed_reg <= 1'b1;
    end

endmodule

>>> src/llrm_framer.sv
`timescale 1ns / 1ps
// Line framing, length/overflow tracking and per-keyword alive bits.
// Depends on llrm_pkg; row data from llrm_kw_rom.
module llrm_framer #(
    parameter int LINE_MAX = 96
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     accept,
    input  logic [1:0]               func,
    input  logic [7:0]               rx_byte,
    input  llrm_pkg::kw_row_t        row,
    output logic [llrm_pkg::ROW_W-1:0] row_addr,
    output llrm_pkg::line_ev_t       ev
);
    import llrm_pkg::*;

    localparam int LEN_W = $clog2(LINE_MAX);

    logic [LEN_W-1:0] length_reg, length_next;
    logic             ovf_reg, ovf_next;
    logic [KW_W-1:0]  alive_reg, alive_next;
    logic [KW_W-1:0]  alive_step;
    logic             printable;
    logic             eol;
    logic [KW_COUNT-1:0] hits;

    // Alive update for the current byte; row matches the current length
    always_comb
    begin
        alive_step = alive_reg;
        for (int k = 0; k < KW_COUNT; k++)
        begin
            if (row.in_range[k])
            begin
                if (row.chars[k] != rx_byte)
                    alive_step[k] = 1'b0;
            end
            else if (!KW_PREFIX[k])
            begin
                alive_step[k] = 1'b0;
            end
        end
    end

    always_comb
    begin
        for (int k = 0; k < KW_COUNT; k++)
        begin
            if (KW_PREFIX[k])
                hits[k] = alive_reg[k] && (length_reg >= LEN_W'(KW_LEN[k]));
            else
                hits[k] = alive_reg[k] && (length_reg == LEN_W'(KW_LEN[k]));
        end
    end

    assign printable = (rx_byte >= CH_FIRST) && (rx_byte <= CH_LAST);

    always_comb
    begin
        length_next = length_reg;
        ovf_next    = ovf_reg;
        alive_next  = alive_reg;
        eol         = 1'b0;
        if (accept)
        begin
            case (func_t'(func))
                FN_BYTE:
                begin
                    if (rx_byte == CH_CR)
                    begin
                        length_next = length_reg;
                    end
                    else if (rx_byte == CH_LF)
                    begin
                        eol         = !ovf_reg && (length_reg != '0);
                        length_next = '0;
                        ovf_next    = 1'b0;
                        alive_next  = '1;
                    end
                    else if (!printable)
                    begin
                        length_next = '0;
                        ovf_next    = 1'b0;
                        alive_next  = '1;
                    end
                    else if (!ovf_reg)
                    begin
                        if (length_reg < LEN_W'(LINE_MAX - 1))
                        begin
                            alive_next  = alive_step;
                            length_next = length_reg + 1'b1;
                        end
                        else
                        begin
                            ovf_next = 1'b1;
                        end
                    end
                end
                FN_FLUSH:
                begin
                    length_next = '0;
                    ovf_next    = 1'b0;
                    alive_next  = '1;
                end
                default:
                begin
                    length_next = length_reg;
                end
            endcase
        end
    end

    assign ev = {eol, hits};

    // Past the longest keyword every row reads the same
    assign row_addr = (length_next >= LEN_W'(KW_MAX_LEN)) ? ROW_W'(KW_MAX_LEN)
                                                        : ROW_W'(length_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            length_reg <= '0;
            ovf_reg    <= 1'b0;
            alive_reg  <= '1;
        end
        else
        begin
            length_reg <= length_next;
            ovf_reg    <= ovf_next;
            alive_reg  <= alive_next;
        end
    end

endmodule

>>> src/llrm_decode.sv
`timescale 1ns / 1ps
// Line decode, wait and peer-state tracking, result output register.
// Depends on llrm_pkg and llrm_if.
module llrm_decode (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic [1:0]          func,
    input  logic [2:0]          wait_kind,
    input  llrm_pkg::line_ev_t  ev,
    llrm_out_if.source          result
);
    import llrm_pkg::*;

    logic       armed_reg, armed_next;
    logic [2:0] kind_reg, kind_next;
    logic [2:0] peer_reg, peer_next;
    logic       rdy_reg, rdy_next;
    logic       vld_reg, vld_next;

    logic       host_reg;
    logic [2:0] action_reg, parsed_reg, cached_reg;
    logic       done_reg, fault_done_reg, link_reg;

    logic       host, fault, match, done;
    logic [2:0] action, parsed;

    always_comb
    begin
        host   = ev.hits[KW_HOST];
        fault  = ev.hits[KW_FAULT];
        action = 3'd0;
        parsed = ST_UNKNOWN;
        for (int k = KW_HOST_FIRST; k < KW_COUNT; k++)
        begin
            if (ev.hits[k])
                action = KW_CODE[k];
        end
        for (int k = KW_ST_FIRST; k < KW_HOST_FIRST; k++)
        begin
            if (ev.hits[k])
                parsed = KW_CODE[k];
        end
        if (parsed == ST_UNKNOWN && fault)
            parsed = ST_FAULT;
        if (host)
            parsed = ST_UNKNOWN;
        else
            action = 3'd0;

        match = fault
            || (kind_reg == WK_PONG     && ev.hits[KW_PONG])
            || (kind_reg == WK_STATE    && ev.hits[KW_STATE])
            || (kind_reg == WK_ACK_REL  && ev.hits[KW_ACK_REL])
            || (kind_reg == WK_ACK_TAKE && ev.hits[KW_ACK_TAKE]);
        done = ev.eol && !host && armed_reg && match;
    end

    always_comb
    begin
        armed_next = armed_reg;
        kind_next  = kind_reg;
        peer_next  = peer_reg;
        rdy_next   = rdy_reg;
        if (accept)
        begin
            case (func_t'(func))
                FN_ARM:
                begin
                    armed_next = 1'b1;
                    kind_next  = wait_kind;
                end
                FN_CANCEL:
                begin
                    armed_next = 1'b0;
                    kind_next  = 3'd0;
                end
                default:
                begin
                    armed_next = armed_reg;
                end
            endcase
        end
        if (ev.eol && !host && parsed != ST_UNKNOWN)
            peer_next = parsed;
        if (done)
        begin
            armed_next = 1'b0;
            rdy_next   = !fault;
        end
        vld_next = ev.eol ? 1'b1 : (result.ready ? 1'b0 : vld_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg <= 1'b0;
            kind_reg  <= 3'd0;
            peer_reg  <= ST_UNKNOWN;
            rdy_reg   <= 1'b0;
            vld_reg   <= 1'b0;
        end
        else
        begin
            armed_reg <= armed_next;
            kind_reg  <= kind_next;
            peer_reg  <= peer_next;
            rdy_reg   <= rdy_next;
            vld_reg   <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ev.eol)
        begin
            host_reg       <= host;
            action_reg     <= action;
            parsed_reg     <= parsed;
            cached_reg     <= peer_next;
            done_reg       <= done;
            fault_done_reg <= done && fault;
            link_reg       <= rdy_next;
        end
    end

    assign result.valid             = vld_reg;
    assign result.is_host_line      = host_reg;
    assign result.host_action       = action_reg;
    assign result.parsed_state      = parsed_reg;
    assign result.cached_peer_state = cached_reg;
    assign result.wait_done         = done_reg;
    assign result.wait_fault        = fault_done_reg;
    assign result.link_ready        = link_reg;

endmodule

>>> src/link_line_receiver_matcher.sv
`timescale 1ns / 1ps
// Top level of the serial link line receiver and keyword matcher.
// Depends on llrm_pkg, llrm_if, llrm_kw_rom, llrm_framer, llrm_decode.

// Takes one beat per clock: received bytes, idle flushes, wait arm and
// cancel. Bytes are framed into lines (CR skipped, LF ends a line, other
// non-printable bytes or a flush drop the partial line, more than
// LINE_MAX-1 printable bytes discard the line). Every printable byte is
// checked against all keywords at once; the keyword characters for the
// current line position come from a table memory whose row is read ahead,
// addressed by the next line length. Throughput is one beat per cycle; a
// line's result is registered in the cycle after its LF beat. While that
// result waits unaccepted the input is held off; a new beat is taken again
// in the cycle the sink takes the result. After reset the block holds ready
// low for one cycle while the first table row is fetched. Each completed
// non-empty line yields one result beat: host action for host-prefixed
// lines, otherwise parsed peer state, cached state and wait completion.
module link_line_receiver_matcher #(
    parameter int LINE_MAX = 96
) (
    input  logic       clk,
    input  logic       rst_n,
    llrm_in_if.sink    item,
    llrm_out_if.source result
);
    import llrm_pkg::*;

    logic              accept;
    logic              primed;
    logic [ROW_W-1:0]  row_addr;
    kw_row_t           row;
    line_ev_t          ev;

    // Output register frees up as soon as the sink takes its beat
    assign item.ready = primed && (!result.valid || result.ready);
    assign accept     = item.valid && item.ready;

    llrm_kw_rom u_rom (
        .clk        (clk),
        .rst_n      (rst_n),
        .addr       (row_addr),
        .row_reg    (row),
        .primed_reg (primed)
    );

    llrm_framer #(
        .LINE_MAX (LINE_MAX)
    ) u_framer (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .func     (item.func),
        .rx_byte  (item.rx_byte),
        .row      (row),
        .row_addr (row_addr),
        .ev       (ev)
    );

    llrm_decode u_decode (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .func      (item.func),
        .wait_kind (item.wait_kind),
        .ev        (ev),
        .result    (result)
    );

endmodule
